@@ sv/stack_access_address_check_macros.svh @@
// assertion helpers for the stack access address check
`ifndef STACK_ACCESS_ADDRESS_CHECK_MACROS_SVH
`define STACK_ACCESS_ADDRESS_CHECK_MACROS_SVH

// same-cycle implication, off while in reset
`define SACC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define SACC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sacc_pkg.sv @@
package sacc_pkg;

  localparam int unsigned AddrW = 32;

  localparam logic [15:0] TypeMask  = 16'h009E;
  localparam logic [15:0] TypeWant  = 16'h0092;
  localparam int unsigned BBitPos   = 14;
  localparam int unsigned HalfW     = 16;

  typedef enum logic [1:0] {
    CFG_PRESENT = 2'd0,
    CFG_RIGHTS  = 2'd1,
    CFG_BASE    = 2'd2,
    CFG_LIMIT   = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_e;

  typedef struct packed {
    logic             func;
    logic [AddrW-1:0] stack_pointer;
    logic [2:0]       operand_size;
  } in_word_t;

  typedef struct packed {
    logic             ok;
    logic [AddrW-1:0] lin_addr;
    logic [AddrW-1:0] next_stack_pointer;
  } out_word_t;

  // after pointer update and offset selection
  typedef struct packed {
    logic             valid;
    logic             pre_ok;
    logic             pop_ovf;
    logic [1:0]       size_m1;
    logic [AddrW-1:0] offset;
    logic [AddrW-1:0] next_sp;
  } prep_t;

  // after limit compare and base add
  typedef struct packed {
    logic             valid;
    logic             ok;
    logic [1:0]       size_m1;
    logic [AddrW:0]   linear;
    logic [AddrW-1:0] next_sp;
  } span_t;

endpackage

@@ sv/stack_access_address_check.sv @@
// Stack access address check. One word is taken on every clock where start is high;
// busy stays low, so a new access may be issued each cycle. Each access gives one
// result word on out_word, marked by out_valid for a single cycle, once it has passed
// pointer update, limit compare with base add, then the address-space overflow check,
// which each take one register stage. The result cannot be held off, so it must be
// captured when out_valid is high. Descriptor registers are written through
// cfg_we/cfg_index/cfg_data and should only change while no access is in flight.
// A fault returns ok low with zero address and pointer.
`include "stack_access_address_check_macros.svh"

module stack_access_address_check (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  sacc_pkg::in_word_t           in_word,
  output logic                         out_valid,
  output sacc_pkg::out_word_t          out_word,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [sacc_pkg::AddrW-1:0]   cfg_data
);
  import sacc_pkg::*;

  logic             desc_present_r;
  logic [15:0]      desc_rights_r;
  logic [AddrW-1:0] desc_base_r;
  logic [AddrW-1:0] desc_limit_r;
  logic             in_valid;
  prep_t            prep;
  span_t            span;

  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_present_r <= 1'b0;
      desc_rights_r  <= '0;
      desc_base_r    <= '0;
      desc_limit_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_PRESENT: desc_present_r <= cfg_data[0];
        CFG_RIGHTS:  desc_rights_r  <= cfg_data[15:0];
        CFG_BASE:    desc_base_r    <= cfg_data;
        CFG_LIMIT:   desc_limit_r   <= cfg_data;
        default:     ;
      endcase
    end
  end

  sacc_prep u_prep (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_word            (in_word),
    .desc_present       (desc_present_r),
    .desc_access_rights (desc_rights_r),
    .prep               (prep)
  );

  sacc_span u_span (
    .clk        (clk),
    .rst_n      (rst_n),
    .prep       (prep),
    .desc_base  (desc_base_r),
    .desc_limit (desc_limit_r),
    .span       (span)
  );

  sacc_resolve u_resolve (
    .clk       (clk),
    .rst_n     (rst_n),
    .span      (span),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  `SACC_ASSERT_NEXT(a_latency, start && !busy, ##1 span.valid ##1 out_valid, "accepted word did not reach the output in three cycles")
  `SACC_ASSERT_NOW(a_fault_zero, out_valid && !out_word.ok, out_word.lin_addr == '0 && out_word.next_stack_pointer == '0, "fault result carries nonzero address or pointer")
  `SACC_ASSERT_NOW(a_ok_desc, out_valid && out_word.ok, desc_present_r && ((desc_rights_r & TypeMask) == TypeWant), "access allowed with a bad descriptor")

endmodule

@@ sv/sacc_prep.sv @@
module sacc_prep (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  sacc_pkg::in_word_t in_word,
  input  logic               desc_present,
  input  logic [15:0]        desc_access_rights,
  output sacc_pkg::prep_t    prep
);
  import sacc_pkg::*;

  logic             big;
  logic             size_ok;
  logic             pop;
  logic [AddrW-1:0] sp;
  logic [AddrW-1:0] size_ext;
  logic [AddrW-1:0] push_sp;
  logic [AddrW:0]   pop_sum;
  logic [HalfW-1:0] pop_lo;
  prep_t            prep_nxt;
  prep_t            prep_r;

  always_comb begin
    sp       = in_word.stack_pointer;
    pop      = (in_word.func == FUNC_POP);
    big      = desc_access_rights[BBitPos];
    size_ok  = (in_word.operand_size == 3'd2) || (in_word.operand_size == 3'd4);
    size_ext = {{(AddrW-3){1'b0}}, in_word.operand_size};

    // 16-bit mode keeps the upper half and wraps the lower one
    push_sp  = sp - size_ext;
    if (!big) push_sp[AddrW-1:HalfW] = sp[AddrW-1:HalfW];
    pop_sum  = {1'b0, sp} + {1'b0, size_ext};
    pop_lo   = sp[HalfW-1:0] + size_ext[HalfW-1:0];

    prep_nxt.valid   = in_valid;
    prep_nxt.pre_ok  = desc_present
                       && ((desc_access_rights & TypeMask) == TypeWant)
                       && size_ok;
    prep_nxt.size_m1 = in_word.operand_size[1:0] - 2'd1;
    prep_nxt.pop_ovf = pop && big && pop_sum[AddrW];
    if (pop) begin
      prep_nxt.offset  = big ? sp : {{(AddrW-HalfW){1'b0}}, sp[HalfW-1:0]};
      prep_nxt.next_sp = big ? pop_sum[AddrW-1:0] : {sp[AddrW-1:HalfW], pop_lo};
    end else begin
      prep_nxt.offset  = big ? push_sp : {{(AddrW-HalfW){1'b0}}, push_sp[HalfW-1:0]};
      prep_nxt.next_sp = push_sp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r <= '0;
    end else begin
      prep_r <= prep_nxt;
    end
  end

  assign prep = prep_r;

endmodule

@@ sv/sacc_span.sv @@
module sacc_span (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sacc_pkg::prep_t       prep,
  input  logic [sacc_pkg::AddrW-1:0] desc_base,
  input  logic [sacc_pkg::AddrW-1:0] desc_limit,
  output sacc_pkg::span_t       span
);
  import sacc_pkg::*;

  logic [AddrW:0] last;
  span_t          span_nxt;
  span_t          span_r;

  always_comb begin
    last             = {1'b0, prep.offset} + {{(AddrW-1){1'b0}}, prep.size_m1};
    span_nxt.valid   = prep.valid;
    span_nxt.ok      = prep.pre_ok && !prep.pop_ovf && (last <= {1'b0, desc_limit});
    span_nxt.size_m1 = prep.size_m1;
    span_nxt.linear  = {1'b0, desc_base} + {1'b0, prep.offset};
    span_nxt.next_sp = prep.next_sp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= '0;
    end else begin
      span_r <= span_nxt;
    end
  end

  assign span = span_r;

endmodule

@@ sv/sacc_resolve.sv @@
module sacc_resolve (
  input  logic                clk,
  input  logic                rst_n,
  input  sacc_pkg::span_t     span,
  output logic                out_valid,
  output sacc_pkg::out_word_t out_word
);
  import sacc_pkg::*;

  logic [AddrW+1:0] lin_end;
  logic             ok;
  logic             out_valid_r;
  out_word_t        out_word_nxt;
  out_word_t        out_word_r;

  always_comb begin
    // linear span must not run past the top of the address space
    lin_end = {1'b0, span.linear} + {{AddrW{1'b0}}, span.size_m1};
    ok      = span.ok && (lin_end[AddrW+1:AddrW] == 2'b00);
    out_word_nxt.ok                 = ok;
    out_word_nxt.lin_addr           = ok ? span.linear[AddrW-1:0] : '0;
    out_word_nxt.next_stack_pointer = ok ? span.next_sp : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= span.valid;
    end
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
